@@ hw/rtl/lpm_pkg.sv @@
// Shared types and constants for the LIKE pattern matcher.
package lpm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int WORD_COUNT      = 4;
  localparam int BYTES_PER_WORD  = CFG_DATA_W / BYTE_W;

  localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h25;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              has_byte;
    logic              last_byte;
  } text_item_t;

endpackage

@@ hw/rtl/lpm_cfg_regs.sv @@
// Pattern configuration registers and the per-position flags derived from them.
module lpm_cfg_regs
  import lpm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [CFG_INDEX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_wdata,
  output logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes,
  output logic [PATTERN_MAX-1:0]             wild_used,
  output logic [PATTERN_MAX-1:0]             byte_used,
  output logic [PATTERN_MAX:0]               pos_mask,
  output logic [LW-1:0]                      len_sel
);

  localparam logic [LEN_W-1:0] PM_LEN = LEN_W'(PATTERN_MAX);

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] words_r [WORD_COUNT];
  logic [LEN_W-1:0]      len_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      for (int w = 0; w < WORD_COUNT; w++) begin
        words_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: len_r      <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_WORD_0: words_r[0] <= cfg_wdata;
        REG_PATTERN_WORD_1: words_r[1] <= cfg_wdata;
        REG_PATTERN_WORD_2: words_r[2] <= cfg_wdata;
        REG_PATTERN_WORD_3: words_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate the programmed length to the pattern storage
  assign len_use = (len_r > PM_LEN) ? PM_LEN : len_r;
  assign len_sel = len_use[LW-1:0];

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_mask
    assign pos_mask[i] = (LEN_W'(i) <= len_use);
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    assign pat_bytes[i] = words_r[i / BYTES_PER_WORD][BYTE_W*(i % BYTES_PER_WORD) +: BYTE_W];
    assign wild_used[i] = (pat_bytes[i] == WILDCARD_BYTE) && pos_mask[i+1];
    assign byte_used[i] = (pat_bytes[i] != WILDCARD_BYTE) && pos_mask[i+1];
  end

endmodule

@@ hw/rtl/lpm_eps_close.sv @@
// Epsilon closure over wildcard positions as a log-depth prefix network.
module lpm_eps_close
  import lpm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic [PATTERN_MAX:0]   vec_i,
  input  logic [PATTERN_MAX:0]   pos_mask,
  input  logic [PATTERN_MAX-1:0] wild_used,
  output logic [PATTERN_MAX:0]   vec_o
);

  localparam int NL = $clog2(PATTERN_MAX + 1);

  // gen: position active; prp: activity passes from position i-1 into i
  logic [PATTERN_MAX:0] gen_lvl [NL+1];
  logic [PATTERN_MAX:0] prp_lvl [NL];

  assign gen_lvl[0] = vec_i & pos_mask;
  assign prp_lvl[0] = {wild_used, 1'b0};

  for (genvar l = 0; l < NL; l++) begin : g_lvl
    for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_comb
        assign gen_lvl[l+1][i] = gen_lvl[l][i] | (prp_lvl[l][i] & gen_lvl[l][i-(1<<l)]);
        if (l + 1 < NL) begin : g_p
          assign prp_lvl[l+1][i] = prp_lvl[l][i] & prp_lvl[l][i-(1<<l)];
        end
      end else begin : g_pass
        assign gen_lvl[l+1][i] = gen_lvl[l][i];
        if (l + 1 < NL) begin : g_p
          assign prp_lvl[l+1][i] = prp_lvl[l][i];
        end
      end
    end
  end

  assign vec_o = gen_lvl[NL];

endmodule

@@ hw/rtl/lpm_nfa_step.sv @@
// One text byte through the position vector, plus the end-of-text match test.
module lpm_nfa_step
  import lpm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int LW = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX:0]               vec_i,
  input  text_item_t                         item,
  input  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes,
  input  logic [PATTERN_MAX-1:0]             wild_used,
  input  logic [PATTERN_MAX-1:0]             byte_used,
  input  logic [PATTERN_MAX:0]               pos_mask,
  input  logic [LW-1:0]                      len_sel,
  output logic [PATTERN_MAX:0]               vec_nxt,
  output logic                               matched
);

  logic [PATTERN_MAX:0]   pre_eps;
  logic [PATTERN_MAX:0]   post_byte;
  logic [PATTERN_MAX:0]   end_eps;
  logic [PATTERN_MAX-1:0] byte_hit;
  logic [PATTERN_MAX-1:0] stay;

  lpm_eps_close #(.PATTERN_MAX(PATTERN_MAX)) u_eps_pre (
    .vec_i     (vec_i),
    .pos_mask  (pos_mask),
    .wild_used (wild_used),
    .vec_o     (pre_eps)
  );

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_hit
    assign byte_hit[i] = pre_eps[i] && byte_used[i] && (pat_bytes[i] == item.text_byte);
    assign stay[i]     = pre_eps[i] && wild_used[i];
  end

  // Wildcards hold their position, literal hits advance by one
  assign post_byte = {1'b0, stay} | {byte_hit, 1'b0};

  // An item without a byte leaves the vector untouched
  assign vec_nxt = item.has_byte ? post_byte : vec_i;

  lpm_eps_close #(.PATTERN_MAX(PATTERN_MAX)) u_eps_end (
    .vec_i     (vec_nxt),
    .pos_mask  (pos_mask),
    .wild_used (wild_used),
    .vec_o     (end_eps)
  );

  assign matched = end_eps[len_sel];

endmodule

@@ hw/rtl/like_pattern_matcher_core.sv @@
// Top level of the LIKE pattern matcher with '%' as the only wildcard.
// An end-of-text item passes the input stage, then its result is registered.
// Throughput: one text byte per cycle; an end-of-text item stalls while the
// result register is full and out_ready is low.
// Reset (synchronous, rst_n low): config registers clear to zero, the position
// vector returns to position zero, input and result stages empty.
module like_pattern_matcher_core
  import lpm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      in_text_byte,
  input  logic                   in_has_byte,
  input  logic                   in_last_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_matched,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam logic [PATTERN_MAX:0] START_VEC = {{PATTERN_MAX{1'b0}}, 1'b1};

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes;
  logic [PATTERN_MAX-1:0]             wild_used;
  logic [PATTERN_MAX-1:0]             byte_used;
  logic [PATTERN_MAX:0]               pos_mask;
  logic [LW-1:0]                      len_sel;

  logic                 stage_vld_r;
  text_item_t           stage_item_r;
  logic [PATTERN_MAX:0] vec_r;
  logic [PATTERN_MAX:0] vec_nxt;
  logic                 match_nxt;
  logic                 out_vld_r;
  logic                 out_matched_r;
  logic                 out_free;
  logic                 stage_go;
  logic                 in_fire;

  lpm_cfg_regs #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pat_bytes (pat_bytes),
    .wild_used (wild_used),
    .byte_used (byte_used),
    .pos_mask  (pos_mask),
    .len_sel   (len_sel)
  );

  lpm_nfa_step #(.PATTERN_MAX(PATTERN_MAX)) u_nfa (
    .vec_i     (vec_r),
    .item      (stage_item_r),
    .pat_bytes (pat_bytes),
    .wild_used (wild_used),
    .byte_used (byte_used),
    .pos_mask  (pos_mask),
    .len_sel   (len_sel),
    .vec_nxt   (vec_nxt),
    .matched   (match_nxt)
  );

  // Only an end-of-text transaction needs room in the result register
  assign out_free = !out_vld_r || out_ready;
  assign stage_go = stage_vld_r && (!stage_item_r.last_byte || out_free);
  assign in_ready = !stage_vld_r || stage_go;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_fire) begin
      stage_vld_r <= 1'b1;
    end else if (stage_go) begin
      stage_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_item_r.text_byte <= in_text_byte;
      stage_item_r.has_byte  <= in_has_byte;
      stage_item_r.last_byte <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= START_VEC;
    end else if (stage_go) begin
      vec_r <= stage_item_r.last_byte ? START_VEC : vec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_go && stage_item_r.last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && stage_item_r.last_byte) begin
      out_matched_r <= match_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_matched = out_matched_r;

endmodule

@@ hw/rtl/lpm_checker.sv @@
// Port-level checks for the LIKE pattern matcher, bound to the top level.
module lpm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last_byte,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched))
    else $error("result changed while stalled");

  // Drop pending results on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result follows an accepted end-of-text transaction
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2))
    else $error("result without end-of-text transaction");

  // Never stall the input while the result side is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind like_pattern_matcher_core lpm_checker u_lpm_checker (.*);

@@ bench/like_pattern_matcher_core_tb.sv @@
// Self-checking testbench for like_pattern_matcher_core: directed table, then random texts.
`timescale 1ns / 100ps

module like_pattern_matcher_core_tb;
  import lpm_pkg::*;

  localparam int PATTERN_MAX    = PATTERN_MAX_DEF;
  localparam int RANDOM_ITEMS   = 850;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int HOLD_PHASE     = 2;

  localparam logic [BYTE_W-1:0] CHAR_A          = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_B          = 8'h62;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_B    = 8'h42;
  localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;

  typedef struct packed {
    bit                is_write;
    cfg_reg_t          reg_sel;
    logic [31:0]       value;
    logic [BYTE_W-1:0] text;
    bit                has;
    bit                last;
    bit                typed;
    bit                want;
  } step_t;

  // write rows: is_write, register, value; item rows: text, has, last, typed, want
  step_t directed_steps [28] = '{
    // reset pattern is empty: only empty text matches
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_A, 1'b1, 1'b1, 1'b1, 1'b0},
    // oversized length saturates, pattern all wildcards
    '{1'b1, REG_PATTERN_LENGTH, 32'h1F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_PATTERN_WORD_0, 32'h25252525, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_PATTERN_WORD_1, 32'h25252525, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_PATTERN_WORD_2, 32'h25252525, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_PATTERN_WORD_3, 32'h25252525, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
    // pattern a % _ B
    '{1'b1, REG_PATTERN_LENGTH, 32'h4, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_PATTERN_WORD_0, 32'h425F2561, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_A, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_UPPER_B, 1'b1, 1'b1, 1'b0, 1'b0},
    // case counts
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_A, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_B, 1'b1, 1'b1, 1'b0, 1'b0},
    // no-byte item that does not end the text, then empty text
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
    // dead state after the first byte
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h7A, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_A, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_UPPER_B, 1'b1, 1'b1, 1'b0, 1'b0},
    // shorten the pattern in the middle of a text
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, CHAR_A, 1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, REG_PATTERN_LENGTH, 32'h1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, REG_PATTERN_LENGTH, 32'h0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      in_text_byte = '0;
  logic                   in_has_byte = 1'b0;
  logic                   in_last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_matched;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // matcher state as the predictor sees it
  logic [LEN_W-1:0]      exp_len_reg = '0;
  logic [CFG_DATA_W-1:0] exp_words [WORD_COUNT] = '{default: '0};
  logic [16:0]           exp_positions = 17'h1;

  bit expected_matches [$];
  int fail_count = 0;
  int text_items = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;

  like_pattern_matcher_core #(
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_text_byte(in_text_byte),
    .in_has_byte (in_has_byte),
    .in_last_byte(in_last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_matched (out_matched),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic int pattern_len_in_use();
    int n;
    n = exp_len_reg;
    if (n > PATTERN_MAX) n = PATTERN_MAX;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_char(int pos);
    return exp_words[pos / BYTES_PER_WORD][BYTE_W * (pos % BYTES_PER_WORD) +: BYTE_W];
  endfunction

  // Pass activity forward through wildcard positions, chains included.
  function automatic logic [16:0] wildcard_closure(logic [16:0] vec, int len);
    logic [16:0] v;
    v = vec & ((17'h1 << (len + 1)) - 1);
    for (int i = 0; i < len; i++) begin
      if (v[i] && pattern_char(i) == WILDCARD_BYTE) v[i + 1] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [16:0] advance_positions(logic [16:0] vec, int len,
                                                    logic [BYTE_W-1:0] c);
    logic [16:0] v;
    logic [16:0] nxt;
    v = wildcard_closure(vec, len);
    nxt = '0;
    for (int i = 0; i < len; i++) begin
      if (v[i]) begin
        if (pattern_char(i) == WILDCARD_BYTE) nxt[i] = 1'b1;
        else if (pattern_char(i) == c) nxt[i + 1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  function automatic void step_matcher(input logic [BYTE_W-1:0] c, input bit has,
                                       input bit last, output bit gives,
                                       output bit match);
    int len;
    logic [16:0] closed;
    len = pattern_len_in_use();
    if (has) exp_positions = advance_positions(exp_positions, len, c);
    gives = last;
    match = 1'b0;
    if (last) begin
      closed = wildcard_closure(exp_positions, len);
      match = closed[len];
      exp_positions = 17'h1;
    end
  endfunction

  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_text_byte();
    case ($urandom_range(0, 7))
      0: return CHAR_A;
      1: return CHAR_B;
      2: return CHAR_UNDERSCORE;
      3: return WILDCARD_BYTE;
      4: return CHAR_UPPER_B;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH: exp_len_reg = data[LEN_W-1:0];
      REG_PATTERN_WORD_0: exp_words[0] = data;
      REG_PATTERN_WORD_1: exp_words[1] = data;
      REG_PATTERN_WORD_2: exp_words[2] = data;
      REG_PATTERN_WORD_3: exp_words[3] = data;
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [BYTE_W-1:0] c, input bit has, input bit last,
                           input bit typed, input bit want);
    int gap;
    bit gives;
    bit match;
    gap = idle_len(tx_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_text_byte <= c;
    in_has_byte <= has;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    step_matcher(c, has, last, gives, match);
    if (gives) expected_matches.insert(expected_matches.size(), typed ? want : match);
    if (has || last) text_items++;
  endtask

  // Hold the input off until every result is back, then let the pipeline empty.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_matches.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_random_pattern();
    logic [LEN_W-1:0] n;
    logic [CFG_DATA_W-1:0] w;
    case ($urandom_range(0, 9))
      0: n = '0;
      1: n = LEN_W'(PATTERN_MAX);
      2: n = LEN_W'($urandom_range(PATTERN_MAX + 1, 31));
      3: n = '1;
      default: n = LEN_W'($urandom_range(1, 8));
    endcase
    write_reg(REG_PATTERN_LENGTH, {($urandom_range(0, 3) == 0) ? 27'($urandom) : 27'd0, n});
    for (int k = 0; k < WORD_COUNT; k++) begin
      case ($urandom_range(0, 19))
        0: w = '0;
        1: w = '1;
        2: w = {BYTES_PER_WORD{WILDCARD_BYTE}};
        default: begin
          for (int b = 0; b < BYTES_PER_WORD; b++) begin
            w[BYTE_W * b +: BYTE_W] = ($urandom_range(0, 99) < 35) ? WILDCARD_BYTE
                                                                    : pick_text_byte();
          end
        end
      endcase
      write_reg(cfg_reg_t'(REG_PATTERN_WORD_0 + k), w);
    end
  endtask

  // Mostly texts built from the pattern, some mutated, some noise or empty; tiny texts hold at most one byte.
  task automatic send_random_text(input bit tiny);
    logic [BYTE_W-1:0] text_q [$];
    logic [BYTE_W-1:0] pc;
    int len;
    bit split_end;
    len = pattern_len_in_use();
    if (tiny) begin
      if ($urandom_range(0, 1)) text_q.insert(text_q.size(), pick_text_byte());
    end else begin
      case ($urandom_range(0, 9))
        0: ;
        1, 2: repeat ($urandom_range(1, 12)) text_q.insert(text_q.size(), pick_text_byte());
        default: begin
          for (int pos = 0; pos < len; pos++) begin
            pc = pattern_char(pos);
            if (pc == WILDCARD_BYTE) begin
              repeat ($urandom_range(0, 3)) text_q.insert(text_q.size(), pick_text_byte());
            end else begin
              text_q.insert(text_q.size(), pc);
            end
          end
          if (text_q.size() > 0 && $urandom_range(0, 4) == 0) begin
            text_q[$urandom_range(0, text_q.size() - 1)] = pick_text_byte();
          end
        end
      endcase
    end
    split_end = (text_q.size() == 0) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(BYTE_W'($urandom), 1'b0, 1'b0, 1'b0, 1'b0);
      end
      send_item(text_q[i], 1'b1, (i == text_q.size() - 1) && !split_end, 1'b0, 1'b0);
    end
    if (split_end) send_item(BYTE_W'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = idle_len(rx_quiet);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $error("matched: no result expected, actual %0b", out_matched);
        fail_count++;
      end else begin
        if (out_matched !== expected_matches[0]) begin
          $error("matched: expected %0b, actual %0b", expected_matches[0], out_matched);
          fail_count++;
        end
        void'(expected_matches.pop_front());
      end
    end
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    step_t s;
    int phase;
    bit hold_phase;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.is_write) begin
        drain_results();
        write_reg(s.reg_sel, s.value);
      end else begin
        send_item(s.text, s.has, s.last, s.typed, s.want);
      end
    end

    text_items = 0;
    phase = 0;
    while (text_items < RANDOM_ITEMS) begin
      drain_results();
      program_random_pattern();
      hold_phase = (phase == HOLD_PHASE);
      tx_quiet = hold_phase || ($urandom_range(0, 4) == 0);
      rx_quiet = tx_quiet && !hold_phase;
      // keep offering short texts while the result side is held off
      if (hold_phase) rx_hold_req = 1'b1;
      repeat (hold_phase ? 40 : $urandom_range(3, 10)) send_random_text(hold_phase);
      // leave a text open so the next pattern takes over mid-string
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(pick_text_byte(), 1'b1, 1'b0, 1'b0, 1'b0);
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      phase++;
    end

    drain_results();
    if (expected_matches.size() != 0) begin
      $error("matched: %0d expected results never arrived", expected_matches.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_cfg_regs.sv
hw/rtl/lpm_eps_close.sv
hw/rtl/lpm_nfa_step.sv
hw/rtl/like_pattern_matcher_core.sv
hw/rtl/lpm_checker.sv
bench/like_pattern_matcher_core_tb.sv
